@@ rtl/aptr_pkg.sv @@
// Shared types, codes and helpers for the AABB pair contact tracker.
package aptr_pkg;

    localparam int ID_W  = 32;
    localparam int KEY_W = 2 * ID_W;
    localparam int CRD_W = 16;
    localparam int EV_W  = 2;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_ENTER = 2'd1;
    localparam logic [EV_W-1:0] EV_STAY  = 2'd2;
    localparam logic [EV_W-1:0] EV_EXIT  = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_UPD
    } t_state;

    // Broadcast from the controller to every cell during the update cycle.
    typedef struct packed {
        logic clr;    // drop all slots
        logic upd;    // apply a check result
        logic alloc;  // no slot matched: lowest free slot takes the pair
        logic hit;    // boxes overlap now
    } t_cell_ctl;

    // Per-cell lookup status, registered at the transfer edge.
    typedef struct packed {
        logic match;  // slot holds the pair
        logic touch;  // slot holds the pair and its flag is set
    } t_cell_stat;

    // One axis: 2*|ca-cb| < sa+sb, exact.
    function automatic logic axis_overlap(
        input logic signed [CRD_W-1:0] ca,
        input logic signed [CRD_W-1:0] cb,
        input logic        [CRD_W-1:0] sa,
        input logic        [CRD_W-1:0] sb
    );
        logic signed [CRD_W:0] diff;
        logic        [CRD_W:0] gap;
        logic        [CRD_W:0] sum;
        diff = {ca[CRD_W-1], ca} - {cb[CRD_W-1], cb};
        gap  = diff[CRD_W] ? (~diff + 1'b1) : diff;
        sum  = {1'b0, sa} + {1'b0, sb};
        return {gap, 1'b0} < {1'b0, sum};
    endfunction

endpackage

@@ rtl/aptr_if.sv @@
// Valid/ready channel interfaces for check items and event results.
interface aptr_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] left_id;
    logic [31:0] right_id;
    logic [1:0]  alive_flags;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0] left_w;
    logic [15:0] left_h;
    logic [15:0] right_w;
    logic [15:0] right_h;

    modport source (
        output valid, cmd, left_id, right_id, alive_flags,
               left_x, left_y, right_x, right_y, left_w, left_h, right_w, right_h,
        input  ready
    );
    modport sink (
        input  valid, cmd, left_id, right_id, alive_flags,
               left_x, left_y, right_x, right_y, left_w, left_h, right_w, right_h,
        output ready
    );
endinterface

interface aptr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic       table_full;

    modport source (output valid, event_res, table_full, input ready);
    modport sink   (input valid, event_res, table_full, output ready);
endinterface

@@ rtl/aptr_cell.sv @@
// One pair slot: key, used and touching flags, and a key compare.
module aptr_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmp_en,
    input  logic [aptr_pkg::KEY_W-1:0]  i_cmp_key,
    input  logic [aptr_pkg::KEY_W-1:0]  i_wr_key,
    input  aptr_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_prev_used,
    output logic                        o_used,
    output aptr_pkg::t_cell_stat        o_stat
);
    import aptr_pkg::*;

    logic             r_used;
    logic             r_touch;
    logic [KEY_W-1:0] r_key;
    logic             r_match;
    logic             w_free_first;

    // Slots fill from the bottom and are only freed all at once,
    // so the first free slot is the one whose lower neighbor is used.
    assign w_free_first = i_prev_used && !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_touch <= 1'b0;
        end else if (i_ctl.clr) begin
            r_used  <= 1'b0;
            r_touch <= 1'b0;
        end else if (i_ctl.upd) begin
            if (r_match) begin
                r_touch <= i_ctl.hit;
            end else if (i_ctl.alloc && w_free_first) begin
                r_used  <= 1'b1;
                r_touch <= i_ctl.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && i_ctl.alloc && w_free_first) begin
            r_key <= i_wr_key;
        end
        if (i_cmp_en) begin
            r_match <= r_used && (r_key == i_cmp_key);
        end
    end

    assign o_used       = r_used;
    assign o_stat.match = r_match;
    assign o_stat.touch = r_match && r_touch;
endmodule

@@ rtl/aabb_pair_contact_tracker.sv @@
// One item at a time: a new item is taken only once the last has left the update state.
// At the transfer edge: every slot cell compares its key, overlap test registered.
// Update state: match flags are OR-reduced across the cell row and the chosen cell updated once the result can load.
// The result waits in an output register; a new item is taken while it waits.
// Reset (synchronous, active low) frees all slots at once; no clearing pass.
module aabb_pair_contact_tracker #(
    parameter int PAIR_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aptr_in_if.sink     i_in,
    aptr_out_if.source  o_out
);
    import aptr_pkg::*;

    t_state r_state, n_state;

    // Request held for the update cycle
    logic             r_is_chk;   // check command with distinct ids
    logic             r_is_clr;
    logic             r_hit;      // both alive and boxes overlap
    logic [KEY_W-1:0] r_key;

    // Result register
    logic             r_out_valid;
    logic [EV_W-1:0]  r_event;
    logic             r_full;
    logic [EV_W-1:0]  n_event;
    logic             n_full;

    logic             w_accept;
    logic             w_load;
    logic             w_hit;
    logic [KEY_W-1:0] w_in_key;
    t_cell_ctl        w_ctl;

    // Cell row signals
    logic [PAIR_SLOTS-1:0] w_used;
    logic [PAIR_SLOTS-1:0] w_match;
    logic [PAIR_SLOTS-1:0] w_touch;
    logic                  w_any_match;
    logic                  w_any_touch;
    logic                  w_no_free;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // Key is left id in the low half, right id in the high half
    assign w_in_key = {i_in.right_id, i_in.left_id};

    assign w_hit = (i_in.alive_flags == 2'b11)
                && axis_overlap(i_in.left_x, i_in.right_x, i_in.left_w, i_in.right_w)
                && axis_overlap(i_in.left_y, i_in.right_y, i_in.left_h, i_in.right_h);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_chk <= (i_in.cmd == CMD_CHECK) && (i_in.left_id != i_in.right_id);
            r_is_clr <= (i_in.cmd == CMD_CLEAR);
            r_hit    <= w_hit;
            r_key    <= w_in_key;
        end
    end

    // Result may be loaded once the output register is empty or draining
    assign w_load = (r_state == S_UPD) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Broadcast to the cells
    always_comb begin
        w_ctl.clr   = w_load && r_is_clr;
        w_ctl.upd   = w_load && r_is_chk;
        w_ctl.alloc = !w_any_match;
        w_ctl.hit   = r_hit;
    end

    // Row of slot cells; each hands its used flag to the next one up
    for (genvar g = 0; g < PAIR_SLOTS; g++) begin : g_cell
        logic       w_prev_used;
        t_cell_stat w_stat;

        if (g == 0) begin : g_first
            assign w_prev_used = 1'b1;
        end else begin : g_rest
            assign w_prev_used = w_used[g-1];
        end

        aptr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmp_en    (w_accept),
            .i_cmp_key   (w_in_key),
            .i_wr_key    (r_key),
            .i_ctl       (w_ctl),
            .i_prev_used (w_prev_used),
            .o_used      (w_used[g]),
            .o_stat      (w_stat)
        );

        assign w_match[g] = w_stat.match;
        assign w_touch[g] = w_stat.touch;
    end

    // Keys are unique, so at most one cell matches
    assign w_any_match = |w_match;
    assign w_any_touch = |w_touch;
    // Slots fill in order: the top slot used means the table is full
    assign w_no_free   = w_used[PAIR_SLOTS-1];

    always_comb begin
        n_event = EV_NONE;
        n_full  = 1'b0;
        if (r_is_chk) begin
            if (w_any_match) begin
                if (r_hit) begin
                    n_event = w_any_touch ? EV_STAY : EV_ENTER;
                end else begin
                    n_event = w_any_touch ? EV_EXIT : EV_NONE;
                end
            end else begin
                // new pair, stored or not, starts out not touching
                n_event = r_hit ? EV_ENTER : EV_NONE;
                n_full  = w_no_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_event <= n_event;
            r_full  <= n_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_event;
    assign o_out.table_full = r_full;
endmodule

@@ rtl/aptr_checker.sv @@
// Port-level checker for the pair contact tracker, bound to the top level.
module aptr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_cmd,
    input logic [31:0] i_left_id,
    input logic [31:0] i_right_id,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_event_res,
    input logic        i_table_full
);
    import aptr_pkg::*;

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && i_in_ready;

    // A held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_event_res) && $stable(i_table_full))
        else $error("result changed while stalled");

    // One item at a time: busy right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in_ready)
        else $error("second item taken during update");

    // A full table only turns a new pair into enter or none
    a_full_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |-> (i_event_res == EV_NONE || i_event_res == EV_ENTER))
        else $error("table full with stay or exit event");

    // With the output empty, the result shows once the update state has loaded the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && !i_out_valid |=> ##1 i_out_valid)
        else $error("result late");

    // Equal ids give none and no full flag
    a_same_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && !i_out_valid && i_cmd == CMD_CHECK && i_left_id == i_right_id
            |=> ##1 (i_event_res == EV_NONE && !i_table_full))
        else $error("equal ids gave an event");
endmodule

bind aabb_pair_contact_tracker aptr_checker u_aptr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_cmd        (i_in.cmd),
    .i_left_id    (i_in.left_id),
    .i_right_id   (i_in.right_id),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_res  (o_out.event_res),
    .i_table_full (o_out.table_full)
);
